[rtl/core/stc_pkg.sv]
package stc_pkg;

    // Pipeline depth: one register stage per entry, the last is the output register
    localparam int unsigned STAGES = 6;

    typedef logic [STAGES-1:0] t_stage_en;

    // Stage positions in the enable vector
    localparam int unsigned ST_SPLIT  = 0;
    localparam int unsigned ST_TOD    = 1;
    localparam int unsigned ST_HOUR   = 2;
    localparam int unsigned ST_REM    = 3;
    localparam int unsigned ST_MINUTE = 4;
    localparam int unsigned ST_OUT    = 5;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // Whole days: (s >> 7) / 675, by a rounded-up reciprocal
    localparam int unsigned DAY_PRESHIFT = 7;
    localparam int unsigned DAY_SHIFT    = 36;
    localparam logic [26:0] DAY_RECIP    =
        27'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

    localparam int unsigned HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP =
        18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

    localparam int unsigned MIN_SHIFT = 18;
    localparam logic [12:0] MIN_RECIP =
        13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    // Julian day conversion
    localparam int unsigned JDN_EPOCH     = 2440588;
    localparam int unsigned JDN_OFFSET    = 32044;
    localparam int unsigned CENT_CYCLE    = 146097;
    localparam int unsigned CENT_FIRST    = 67;
    localparam logic [21:0] A_OFFSET      = 22'(JDN_EPOCH + JDN_OFFSET);
    localparam logic [23:0] CENT_LIM_1    = 24'(CENT_CYCLE * (CENT_FIRST + 1));
    localparam logic [23:0] CENT_LIM_2    = 24'(CENT_CYCLE * (CENT_FIRST + 2));
    localparam logic [21:0] CENT_DAYS_0   = 22'((CENT_CYCLE * CENT_FIRST) / 4);
    localparam logic [21:0] CENT_DAYS_1   = 22'((CENT_CYCLE * (CENT_FIRST + 1)) / 4);
    localparam logic [21:0] CENT_DAYS_2   = 22'((CENT_CYCLE * (CENT_FIRST + 2)) / 4);
    localparam logic [11:0] YEAR_BASE_0   = 12'(100 * CENT_FIRST - 4800);
    localparam logic [11:0] YEAR_BASE_1   = 12'(100 * (CENT_FIRST + 1) - 4800);
    localparam logic [11:0] YEAR_BASE_2   = 12'(100 * (CENT_FIRST + 2) - 4800);

    localparam logic [17:0] QUAD_DAYS  = 18'd1461;
    localparam int unsigned QUAD_SHIFT = 28;
    localparam logic [17:0] QUAD_RECIP =
        18'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);

    localparam int unsigned MSPAN_SHIFT = 19;
    localparam logic [11:0] MSPAN_RECIP =
        12'(((64'd1 << MSPAN_SHIFT) + 64'd152) / 64'd153);

    localparam logic [3:0] MARCH_WRAP = 4'd10;

    // Weekday: JDN mod 7 taken as (days + JDN_EPOCH mod 7) mod 7
    localparam logic [15:0] WEEK_EPOCH = 16'(JDN_EPOCH % 7);
    localparam int unsigned WEEK_SHIFT = 19;
    localparam logic [16:0] WEEK_RECIP =
        17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
    localparam logic [15:0] WEEK_DAYS  = 16'd7;

    typedef enum logic [1:0] {
        CENT_0 = 2'd0,
        CENT_1 = 2'd1,
        CENT_2 = 2'd2
    } t_cent;

    // Day of the March-based year on which month m starts: (153*m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'((153 * 0 + 2) / 5);
            4'd1:    v = 9'((153 * 1 + 2) / 5);
            4'd2:    v = 9'((153 * 2 + 2) / 5);
            4'd3:    v = 9'((153 * 3 + 2) / 5);
            4'd4:    v = 9'((153 * 4 + 2) / 5);
            4'd5:    v = 9'((153 * 5 + 2) / 5);
            4'd6:    v = 9'((153 * 6 + 2) / 5);
            4'd7:    v = 9'((153 * 7 + 2) / 5);
            4'd8:    v = 9'((153 * 8 + 2) / 5);
            4'd9:    v = 9'((153 * 9 + 2) / 5);
            4'd10:   v = 9'((153 * 10 + 2) / 5);
            4'd11:   v = 9'((153 * 11 + 2) / 5);
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/stc_split.sv]
module stc_split (
    input  logic               i_clk,
    input  stc_pkg::t_stage_en i_en,
    input  logic [31:0]        i_seconds_count,
    output logic [31:0]        o_secs,
    output logic [15:0]        o_days
);

    logic [51:0] w_prod;
    logic [31:0] r_secs;
    logic [15:0] r_days;

    assign w_prod = 52'(i_seconds_count[31:stc_pkg::DAY_PRESHIFT]) * 52'(stc_pkg::DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[stc_pkg::ST_SPLIT]) begin
            r_secs <= i_seconds_count;
            r_days <= w_prod[stc_pkg::DAY_SHIFT +: 16];
        end
    end

    assign o_secs = r_secs;
    assign o_days = r_days;

endmodule

[rtl/core/stc_time.sv]
module stc_time (
    input  logic               i_clk,
    input  stc_pkg::t_stage_en i_en,
    input  logic [31:0]        i_secs,
    input  logic [15:0]        i_days,
    output logic [5:0]         o_second,
    output logic [5:0]         o_minute,
    output logic [4:0]         o_hour
);

    logic [31:0] w_day_secs;
    logic [31:0] w_tod;
    logic [34:0] w_hprod;
    logic [16:0] w_rem;
    logic [24:0] w_mprod;
    logic [11:0] w_sec;

    logic [16:0] r_tod2;
    logic [16:0] r_tod3;
    logic [4:0]  r_hour3;
    logic [11:0] r_rem4;
    logic [4:0]  r_hour4;
    logic [11:0] r_rem5;
    logic [4:0]  r_hour5;
    logic [5:0]  r_min5;
    logic [5:0]  r_second;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;

    assign w_day_secs = 32'(i_days) * 32'(stc_pkg::SECS_PER_DAY);
    assign w_tod      = i_secs - w_day_secs;
    assign w_hprod    = 35'(r_tod2) * 35'(stc_pkg::HOUR_RECIP);
    assign w_rem      = r_tod3 - 17'(r_hour3) * stc_pkg::SECS_PER_HOUR;
    assign w_mprod    = 25'(r_rem4) * 25'(stc_pkg::MIN_RECIP);
    assign w_sec      = r_rem5 - 12'(r_min5) * stc_pkg::SECS_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (i_en[stc_pkg::ST_TOD]) begin
            r_tod2 <= w_tod[16:0];
        end
        if (i_en[stc_pkg::ST_HOUR]) begin
            r_tod3  <= r_tod2;
            r_hour3 <= w_hprod[stc_pkg::HOUR_SHIFT +: 5];
        end
        if (i_en[stc_pkg::ST_REM]) begin
            r_rem4  <= w_rem[11:0];
            r_hour4 <= r_hour3;
        end
        if (i_en[stc_pkg::ST_MINUTE]) begin
            r_rem5  <= r_rem4;
            r_hour5 <= r_hour4;
            r_min5  <= w_mprod[stc_pkg::MIN_SHIFT +: 6];
        end
        if (i_en[stc_pkg::ST_OUT]) begin
            r_second <= w_sec[5:0];
            r_minute <= r_min5;
            r_hour   <= r_hour5;
        end
    end

    assign o_second = r_second;
    assign o_minute = r_minute;
    assign o_hour   = r_hour;

endmodule

[rtl/core/stc_date.sv]
module stc_date (
    input  logic               i_clk,
    input  stc_pkg::t_stage_en i_en,
    input  logic [15:0]        i_days,
    output logic [4:0]         o_day,
    output logic [3:0]         o_month,
    output logic [11:0]        o_year,
    output logic [2:0]         o_weekday
);

    logic [21:0]    w_a;
    logic [23:0]    w_a4;
    stc_pkg::t_cent w_cent;
    logic [21:0]    w_cent_days;
    logic [21:0]    w_c;
    logic [15:0]    w_x7;
    logic [32:0]    w_wprod;
    logic [35:0]    w_dprod;
    logic [15:0]    w_wd;
    logic [17:0]    w_qd;
    logic [17:0]    w_e;
    logic [10:0]    w_mx;
    logic [22:0]    w_mprod;
    logic [8:0]     w_dom;
    logic           w_wrap;
    logic [11:0]    w_year_base;

    stc_pkg::t_cent r_cent2, r_cent3, r_cent4, r_cent5;
    logic [15:0]    r_c2, r_c3;
    logic [15:0]    r_x72;
    logic [12:0]    r_wq2;
    logic [6:0]     r_d3, r_d4, r_d5;
    logic [2:0]     r_wd3, r_wd4, r_wd5;
    logic [8:0]     r_e4, r_e5;
    logic [3:0]     r_m5;
    logic [4:0]     r_day;
    logic [3:0]     r_month;
    logic [11:0]    r_year;
    logic [2:0]     r_weekday;

    // Century term b of the conversion only ever takes three values over the input range
    assign w_a  = 22'(i_days) + stc_pkg::A_OFFSET;
    assign w_a4 = {w_a, 2'b11};

    always_comb begin
        if (w_a4 >= stc_pkg::CENT_LIM_2) begin
            w_cent = stc_pkg::CENT_2;
        end else if (w_a4 >= stc_pkg::CENT_LIM_1) begin
            w_cent = stc_pkg::CENT_1;
        end else begin
            w_cent = stc_pkg::CENT_0;
        end
    end

    always_comb begin
        unique case (w_cent)
            stc_pkg::CENT_0: w_cent_days = stc_pkg::CENT_DAYS_0;
            stc_pkg::CENT_1: w_cent_days = stc_pkg::CENT_DAYS_1;
            stc_pkg::CENT_2: w_cent_days = stc_pkg::CENT_DAYS_2;
            default:         w_cent_days = stc_pkg::CENT_DAYS_0;
        endcase
    end

    assign w_c     = w_a - w_cent_days;
    assign w_x7    = i_days + stc_pkg::WEEK_EPOCH;
    assign w_wprod = 33'(w_x7) * 33'(stc_pkg::WEEK_RECIP);

    assign w_dprod = 36'({r_c2, 2'b11}) * 36'(stc_pkg::QUAD_RECIP);
    assign w_wd    = r_x72 - 16'(r_wq2) * stc_pkg::WEEK_DAYS;

    assign w_qd    = 18'(r_d3) * stc_pkg::QUAD_DAYS;
    assign w_e     = 18'(r_c3) - (w_qd >> 2);

    assign w_mx    = 11'(r_e4) * 11'd5 + 11'd2;
    assign w_mprod = 23'(w_mx) * 23'(stc_pkg::MSPAN_RECIP);

    // Months run from March; January and February belong to the next year
    assign w_wrap = (r_m5 >= stc_pkg::MARCH_WRAP);
    assign w_dom  = r_e5 - stc_pkg::month_start(r_m5) + 9'd1;

    always_comb begin
        unique case (r_cent5)
            stc_pkg::CENT_0: w_year_base = stc_pkg::YEAR_BASE_0;
            stc_pkg::CENT_1: w_year_base = stc_pkg::YEAR_BASE_1;
            stc_pkg::CENT_2: w_year_base = stc_pkg::YEAR_BASE_2;
            default:         w_year_base = stc_pkg::YEAR_BASE_0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[stc_pkg::ST_TOD]) begin
            r_cent2 <= w_cent;
            r_c2    <= w_c[15:0];
            r_x72   <= w_x7;
            r_wq2   <= w_wprod[stc_pkg::WEEK_SHIFT +: 13];
        end
        if (i_en[stc_pkg::ST_HOUR]) begin
            r_cent3 <= r_cent2;
            r_c3    <= r_c2;
            r_d3    <= w_dprod[stc_pkg::QUAD_SHIFT +: 7];
            r_wd3   <= w_wd[2:0];
        end
        if (i_en[stc_pkg::ST_REM]) begin
            r_cent4 <= r_cent3;
            r_d4    <= r_d3;
            r_e4    <= w_e[8:0];
            r_wd4   <= r_wd3;
        end
        if (i_en[stc_pkg::ST_MINUTE]) begin
            r_cent5 <= r_cent4;
            r_d5    <= r_d4;
            r_e5    <= r_e4;
            r_m5    <= w_mprod[stc_pkg::MSPAN_SHIFT +: 4];
            r_wd5   <= r_wd4;
        end
        if (i_en[stc_pkg::ST_OUT]) begin
            r_day     <= w_dom[4:0];
            r_month   <= w_wrap ? (r_m5 - 4'd9) : (r_m5 + 4'd3);
            r_year    <= w_year_base + 12'(r_d5) + 12'(w_wrap);
            r_weekday <= r_wd5;
        end
    end

    assign o_day     = r_day;
    assign o_month   = r_month;
    assign o_year    = r_year;
    assign o_weekday = r_weekday;

endmodule

[rtl/core/seconds_to_calendar_date.sv]
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into UTC time of day,
// Gregorian date (through the Julian day number) and weekday, 0 being Monday. The block
// keeps no state and gives one result per transaction. It is a six-stage pipeline that
// takes a new transaction every cycle when not stalled; the output register is the last
// stage. Every division is by a constant, done as a multiplication by a rounded-up
// reciprocal. Each stage holds at most one multiplier on any path, save the month step,
// which multiplies by 5 first. A stalled output holds only the stages that are full:
// bubbles ahead of a stall are filled, so input is still taken while a result waits.
module seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seconds_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic [2:0]  o_weekday
);

    stc_pkg::t_stage_en w_en;
    stc_pkg::t_stage_en r_vld;
    logic [31:0]        w_secs;
    logic [15:0]        w_days;

    // A stage loads when it is empty or the stage after it moves on
    always_comb begin
        w_en[stc_pkg::STAGES-1] = !r_vld[stc_pkg::STAGES-1] || i_ready;
        for (int k = stc_pkg::STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < stc_pkg::STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[stc_pkg::STAGES-1];

    stc_split u_split (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_seconds_count (i_seconds_count),
        .o_secs          (w_secs),
        .o_days          (w_days)
    );

    stc_time u_time (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_secs   (w_secs),
        .i_days   (w_days),
        .o_second (o_second),
        .o_minute (o_minute),
        .o_hour   (o_hour)
    );

    stc_date u_date (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_days    (w_days),
        .o_day     (o_day),
        .o_month   (o_month),
        .o_year    (o_year),
        .o_weekday (o_weekday)
    );

endmodule
